// ===== rtl/tcoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcoa_pkg
// Shared constants, types and register codes of the overlap-add block.
// ----------------------------------------------------------------------------
package tcoa_pkg;

   // Sizing limits
   localparam int MAX_TAPS      = 32;
   localparam int MAX_CHANNELS  = 256;
   localparam int MAX_POSITIONS = 65536;

   // Counter and limit widths
   localparam int TAP_W  = $clog2(MAX_TAPS);
   localparam int CHAN_W = $clog2(MAX_CHANNELS);
   localparam int POS_W  = $clog2(MAX_POSITIONS);
   localparam int K_W    = $clog2(MAX_TAPS + 1);
   localparam int NC_W   = $clog2(MAX_CHANNELS + 1);
   localparam int NP_W   = $clog2(MAX_POSITIONS + 1);

   // Overlap store: one row of tap slots per channel
   localparam int ADDR_W     = CHAN_W + TAP_W;
   localparam int STORE_DEPTH = 2 ** ADDR_W;

   // Field widths
   localparam int SAMPLE_W = 24;
   localparam int SUM_W    = 29;
   localparam int OCHAN_W  = 8;
   localparam int IDX_W    = 21;

   // Configuration register widths
   localparam int TAPS_REG_W      = 6;
   localparam int STRIDE_REG_W    = 6;
   localparam int CHANNELS_REG_W  = 9;
   localparam int POSITIONS_REG_W = 17;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 17;

   // Register reset values
   localparam logic [TAPS_REG_W-1:0]      TAPS_RST      = TAPS_REG_W'(16);
   localparam logic [STRIDE_REG_W-1:0]    STRIDE_RST    = STRIDE_REG_W'(8);
   localparam logic [CHANNELS_REG_W-1:0]  CHANNELS_RST  = CHANNELS_REG_W'(128);
   localparam logic [POSITIONS_REG_W-1:0] POSITIONS_RST = POSITIONS_REG_W'(275);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAPS      = 2'd0,
      CSR_STRIDE    = 2'd1,
      CSR_CHANNELS  = 2'd2,
      CSR_POSITIONS = 2'd3
   } csr_index_type;

   // Clamped transform limits
   typedef struct packed {
      logic [K_W-1:0]  k;
      logic [K_W-1:0]  s;
      logic [NC_W-1:0] nc;
      logic [NP_W-1:0] np;
   } lim_type;

endpackage

`default_nettype wire

// ===== rtl/tcoa_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcoa_req_if
// Input channel: one GEMM column value per transfer.
// ----------------------------------------------------------------------------
interface tcoa_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [tcoa_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcoa_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcoa_rsp_if
// Result channel: one completed output sample per transfer.
// ----------------------------------------------------------------------------
interface tcoa_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tcoa_pkg::SUM_W-1:0]  out_sample;
   logic [tcoa_pkg::OCHAN_W-1:0]       out_channel;
   logic [tcoa_pkg::IDX_W-1:0]         out_index;
   logic                               final_res;

   modport source (output valid, output out_sample, output out_channel,
                   output out_index, output final_res, input ready);
   modport sink   (input valid, input out_sample, input out_channel,
                   input out_index, input final_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcoa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcoa_ram
// Generic single-write, single-read RAM with registered read data.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module tcoa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tcoa_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcoa_cfg
// Configuration registers and their clamping into transform limits.
// ----------------------------------------------------------------------------
module tcoa_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tcoa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcoa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output tcoa_pkg::lim_type               lim
);
   import tcoa_pkg::*;

   logic [TAPS_REG_W-1:0]      taps_ff;
   logic [STRIDE_REG_W-1:0]    stride_ff;
   logic [CHANNELS_REG_W-1:0]  channels_ff;
   logic [POSITIONS_REG_W-1:0] positions_ff;
   logic [K_W-1:0]             k;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff      <= TAPS_RST;
         stride_ff    <= STRIDE_RST;
         channels_ff  <= CHANNELS_RST;
         positions_ff <= POSITIONS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TAPS:      taps_ff      <= csr_wdata[TAPS_REG_W-1:0];
            CSR_STRIDE:    stride_ff    <= csr_wdata[STRIDE_REG_W-1:0];
            CSR_CHANNELS:  channels_ff  <= csr_wdata[CHANNELS_REG_W-1:0];
            CSR_POSITIONS: positions_ff <= csr_wdata[POSITIONS_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp each register into its legal range; stride is bounded by taps
   always_comb begin
      if (taps_ff == '0) begin
         k = K_W'(1);
      end else if (32'(taps_ff) > 32'(MAX_TAPS)) begin
         k = K_W'(MAX_TAPS);
      end else begin
         k = K_W'(taps_ff);
      end
      lim.k = k;

      if (stride_ff == '0) begin
         lim.s = K_W'(1);
      end else if (32'(stride_ff) > 32'(k)) begin
         lim.s = k;
      end else begin
         lim.s = K_W'(stride_ff);
      end

      if (channels_ff == '0) begin
         lim.nc = NC_W'(1);
      end else if (32'(channels_ff) > 32'(MAX_CHANNELS)) begin
         lim.nc = NC_W'(MAX_CHANNELS);
      end else begin
         lim.nc = NC_W'(channels_ff);
      end

      if (positions_ff == '0) begin
         lim.np = NP_W'(1);
      end else if (32'(positions_ff) > 32'(MAX_POSITIONS)) begin
         lim.np = NP_W'(MAX_POSITIONS);
      end else begin
         lim.np = NP_W'(positions_ff);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/transposed_conv_overlap_add.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// transposed_conv_overlap_add
// Streaming 1-D transposed-convolution overlap-add. Values arrive ordered by
// position, channel, tap; the partial sums of each channel's pending output
// samples live in one synchronous overlap RAM.
//
//   port      dir  contents
//   req_ch    in   sample (24b signed GEMM value)
//   rsp_ch    out  out_sample, out_channel, out_index, final_res
//   csr_*     in   write enable, register index, write data
//
// One value per cycle sustained while rsp_ch does not stall; the RAM read and the
// add stage are registered together, and the sum then goes to the output register.
// A write back and a read of the same slot in one cycle are forwarded.
// Synchronous reset clears counters and valids; no clearing pass is run.
// A stall on rsp_ch holds the add stage and then the input side.
// ----------------------------------------------------------------------------
module transposed_conv_overlap_add (
   input  logic                            clock,
   input  logic                            reset,
   tcoa_req_if.sink                        req_ch,
   tcoa_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [tcoa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcoa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tcoa_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       use_ovl;
      logic                       emit;
      logic                       last;
      logic [CHAN_W-1:0]          chan;
      logic [IDX_W-1:0]           idx;
      logic [ADDR_W-1:0]          wr_addr;
   } stage_type;

   localparam int PROD_W = POS_W + K_W;

   lim_type lim;

   // Counters
   logic [TAP_W-1:0]  tap_ff,  tap_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic [POS_W-1:0]  pos_ff,  pos_in;

   // Add stage
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      fwd_ff, fwd_in;
   logic [SUM_W-1:0] fwd_data_ff, fwd_data_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_sample_ff;
   logic [CHAN_W-1:0] rsp_chan_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic             rsp_last_ff;

   // Issue-side decode
   logic [TAP_W-1:0]  t;
   logic [CHAN_W-1:0] c;
   logic [POS_W-1:0]  l;
   logic              last_pos;
   logic [PROD_W-1:0] idx_full;
   logic [ADDR_W-1:0] rd_addr;
   logic              req_xfer;

   // Add-stage datapath
   logic [SUM_W-1:0]        ovl_raw;
   logic signed [SUM_W-1:0] ovl;
   logic signed [SUM_W:0]   acc_wide;
   logic [SUM_W-1:0]        acc_sat;
   logic                    s1_advance;
   logic                    s1_load_ok;
   logic                    out_free;
   logic                    ram_we;

   tcoa_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .lim       (lim)
   );

   tcoa_ram #(
      .WIDTH (SUM_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_ff.wr_addr),
      .wr_data (acc_sat),
      .rd_en   (req_xfer),
      .rd_addr (rd_addr),
      .rd_data (ovl_raw)
   );

   // Handshake: add stage moves when its result has somewhere to go
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign s1_advance = s1_valid_ff && (!s1_ff.emit || out_free);
   assign s1_load_ok = !s1_valid_ff || s1_advance;
   assign req_ch.ready = s1_load_ok;
   assign req_xfer   = req_ch.valid && s1_load_ok;
   assign ram_we     = s1_advance && !s1_ff.emit;

   // Decode the current counters against the limits
   always_comb begin
      t = (32'(tap_ff)  >= 32'(lim.k))  ? '0 : tap_ff;
      c = (32'(chan_ff) >= 32'(lim.nc)) ? '0 : chan_ff;
      l = (32'(pos_ff)  >= 32'(lim.np)) ? '0 : pos_ff;
      last_pos = (32'(l) + 32'd1 == 32'(lim.np));
      idx_full = PROD_W'(l) * PROD_W'(lim.s) + PROD_W'(t);
      rd_addr  = {c, t};

      s1_in.sample  = req_ch.sample;
      s1_in.use_ovl = (l != '0) && (32'(t) + 32'(lim.s) < 32'(lim.k));
      s1_in.emit    = (32'(t) < 32'(lim.s)) || last_pos;
      s1_in.last    = last_pos && (32'(c) + 32'd1 == 32'(lim.nc))
                      && (32'(t) + 32'd1 == 32'(lim.k));
      s1_in.chan    = c;
      s1_in.idx     = idx_full[IDX_W-1:0];
      s1_in.wr_addr = {c, TAP_W'(32'(t) - 32'(lim.s))};

      // Advance tap, then channel, then position
      tap_in  = tap_ff;
      chan_in = chan_ff;
      pos_in  = pos_ff;
      if (req_xfer) begin
         if (32'(t) + 32'd1 >= 32'(lim.k)) begin
            tap_in = '0;
            if (32'(c) + 32'd1 >= 32'(lim.nc)) begin
               chan_in = '0;
               pos_in  = (32'(l) + 32'd1 >= 32'(lim.np)) ? '0 : POS_W'(32'(l) + 32'd1);
            end else begin
               chan_in = CHAN_W'(32'(c) + 32'd1);
               pos_in  = l;
            end
         end else begin
            tap_in  = TAP_W'(32'(t) + 32'd1);
            chan_in = c;
            pos_in  = l;
         end
      end
   end

   // Add the overlap into the new value and saturate to the sum range
   always_comb begin
      ovl      = s1_ff.use_ovl ? signed'(fwd_ff ? fwd_data_ff : ovl_raw) : '0;
      acc_wide = (SUM_W + 1)'(s1_ff.sample) + (SUM_W + 1)'(ovl);
      if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
         acc_sat = {acc_wide[SUM_W], {(SUM_W - 1){!acc_wide[SUM_W]}}};
      end else begin
         acc_sat = acc_wide[SUM_W-1:0];
      end
   end

   // Stage control and forwarding of a write that the new read misses
   always_comb begin
      s1_valid_in = s1_valid_ff;
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
         fwd_in      = ram_we && (s1_ff.wr_addr == rd_addr);
         fwd_data_in = acc_sat;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && s1_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff       <= '0;
         chan_ff      <= '0;
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tap_ff       <= tap_in;
         chan_ff      <= chan_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fwd_data_ff <= fwd_data_in;
      if (req_xfer) begin
         s1_ff <= s1_in;
      end
      if (s1_advance && s1_ff.emit) begin
         rsp_sample_ff <= acc_sat;
         rsp_chan_ff   <= s1_ff.chan;
         rsp_idx_ff    <= s1_ff.idx;
         rsp_last_ff   <= s1_ff.last;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_sample  = rsp_sample_ff;
   assign rsp_ch.out_channel = OCHAN_W'(rsp_chan_ff);
   assign rsp_ch.out_index   = rsp_idx_ff;
   assign rsp_ch.final_res   = rsp_last_ff;

endmodule

`default_nettype wire

// ===== tb/sv/transposed_conv_overlap_add_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transposed_conv_overlap_add_tb
// Self-checking bench for the streaming overlap-add block. A queue-fed driver
// pushes GEMM values with random gaps, a stalling sink takes the completed
// samples, and an in-bench overlap-add predictor builds the expected stream
// for a field-by-field compare. Settings change only while the block is idle.
// ----------------------------------------------------------------------------
module transposed_conv_overlap_add_tb;
   import tcoa_pkg::*;

   localparam int SLOTS          = MAX_TAPS - 1;
   localparam int STORE_SLOTS    = MAX_CHANNELS * SLOTS;
   localparam int RANDOM_ITEMS   = 800;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam longint SUM_HI = longint'(2 ** (SUM_W - 1)) - 1;
   localparam longint SUM_LO = -longint'(2 ** (SUM_W - 1));
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = 24'sh800000;

   typedef logic signed [SAMPLE_W-1:0] sample_q_type [$];

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [OCHAN_W-1:0]      channel;
      logic [IDX_W-1:0]        index;
      logic                    is_final;
   } output_sample_type;

   typedef enum {
      SAMPLE_RANDOM,
      SAMPLE_MAX,
      SAMPLE_MIN,
      SAMPLE_ALTERNATE,
      SAMPLE_SMALL
   } sample_mode_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TAPS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tcoa_req_if req_if ();
   tcoa_rsp_if rsp_if ();

   transposed_conv_overlap_add u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the registers, counters and overlap store
   logic [TAPS_REG_W-1:0]      taps_reg   = TAPS_RST;
   logic [STRIDE_REG_W-1:0]    stride_reg = STRIDE_RST;
   logic [CHANNELS_REG_W-1:0]  chan_reg   = CHANNELS_RST;
   logic [POSITIONS_REG_W-1:0] pos_reg    = POSITIONS_RST;
   int unsigned tap_idx  = 0;
   int unsigned chan_idx = 0;
   int unsigned pos_idx  = 0;
   logic signed [SUM_W-1:0] partial_sum [STORE_SLOTS];
   bit slot_valid [STORE_SLOTS];

   output_sample_type expected_outputs [$];
   sample_q_type      pending_samples;
   sample_q_type      batch;

   int unsigned pushed_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned error_count    = 0;
   int unsigned idle_cycles    = 0;

   int unsigned send_wait = 0, send_stretch = 0;
   int unsigned take_wait = 0, take_stretch = 0;
   bit          send_calm = 1'b0, take_calm = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Wait draw: each long stretch has either random gaps or, one time in four, no gaps
   function automatic int unsigned draw_wait(inout int unsigned stretch, inout bit calm);
      if (stretch == 0) begin
         stretch = $urandom_range(16, 160);
         calm    = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      return calm ? 0 : $urandom_range(0, 10);
   endfunction

   // Clamp raw register values to the limits the block works with
   function automatic lim_type clamp_limits(input logic [TAPS_REG_W-1:0] t,
                                            input logic [STRIDE_REG_W-1:0] s,
                                            input logic [CHANNELS_REG_W-1:0] c,
                                            input logic [POSITIONS_REG_W-1:0] p);
      lim_type lim;
      lim.k  = (t == 0) ? K_W'(1) : (t > MAX_TAPS) ? K_W'(MAX_TAPS) : K_W'(t);
      lim.s  = (s == 0) ? K_W'(1) : (s > lim.k) ? lim.k : K_W'(s);
      lim.nc = (c == 0) ? NC_W'(1) : (c > MAX_CHANNELS) ? NC_W'(MAX_CHANNELS) : NC_W'(c);
      lim.np = (p == 0) ? NP_W'(1) : (p > MAX_POSITIONS) ? NP_W'(MAX_POSITIONS) : NP_W'(p);
      return lim;
   endfunction

   // Drop any counter at or beyond its current limit back to zero
   function automatic void wrap_counters(input lim_type lim,
                                         inout int unsigned t, c, l);
      if (t >= lim.k) t = 0;
      if (c >= lim.nc) c = 0;
      if (l >= lim.np) l = 0;
   endfunction

   // Step tap, then channel, then position
   function automatic void advance_counters(input lim_type lim,
                                            inout int unsigned t, c, l);
      if (t + 1 >= lim.k) begin
         t = 0;
         if (c + 1 >= lim.nc) begin
            c = 0;
            l = (l + 1 >= lim.np) ? 0 : l + 1;
         end else begin
            c = c + 1;
         end
      end else begin
         t = t + 1;
      end
   endfunction

   // Items left until the current transform wraps, under the given limits
   function automatic int unsigned items_to_end(input lim_type lim);
      int unsigned t, c, l;
      t = tap_idx;
      c = chan_idx;
      l = pos_idx;
      wrap_counters(lim, t, c, l);
      return int'(lim.np) * lim.nc * lim.k - ((l * lim.nc + c) * lim.k + t);
   endfunction

   // Dry run: true if the next n items only read overlap slots already written
   function automatic bit reads_covered(input lim_type lim, input int unsigned n);
      bit seen [STORE_SLOTS];
      int unsigned t, c, l;
      seen = slot_valid;
      t = tap_idx;
      c = chan_idx;
      l = pos_idx;
      repeat (n) begin
         wrap_counters(lim, t, c, l);
         if (l > 0 && t < lim.k - lim.s && !seen[c * SLOTS + t]) return 1'b0;
         if (!(t < lim.s || l + 1 == lim.np)) seen[c * SLOTS + t - lim.s] = 1'b1;
         advance_counters(lim, t, c, l);
      end
      return 1'b1;
   endfunction

   // Overlap-add one GEMM value; queue the completed sample if one comes out
   task automatic predict_overlap_add(input logic signed [SAMPLE_W-1:0] x);
      lim_type           lim;
      longint            acc;
      int unsigned       slot;
      bit                last_pos;
      output_sample_type res;
      lim = clamp_limits(taps_reg, stride_reg, chan_reg, pos_reg);
      wrap_counters(lim, tap_idx, chan_idx, pos_idx);
      acc      = longint'(x);
      slot     = chan_idx * SLOTS + tap_idx;
      last_pos = (pos_idx + 1 == lim.np);
      if (pos_idx > 0 && tap_idx < lim.k - lim.s) acc += longint'(partial_sum[slot]);
      if (acc > SUM_HI) acc = SUM_HI;
      else if (acc < SUM_LO) acc = SUM_LO;
      if (tap_idx < lim.s || last_pos) begin
         res.sum      = SUM_W'(acc);
         res.channel  = OCHAN_W'(chan_idx);
         res.index    = IDX_W'(pos_idx * lim.s + tap_idx);
         res.is_final = last_pos && (chan_idx + 1 == lim.nc) && (tap_idx + 1 == lim.k);
         expected_outputs.push_back(res);
      end else begin
         partial_sum[slot - lim.s] = SUM_W'(acc);
         slot_valid[slot - lim.s]  = 1'b1;
      end
      advance_counters(lim, tap_idx, chan_idx, pos_idx);
   endtask

   // Driver: present queued values, with a drawn gap after each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_wait = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_wait > 0) begin
            send_wait--;
            req_if.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            req_if.sample <= pending_samples.pop_front();
            req_if.valid  <= 1'b1;
            send_wait = draw_wait(send_stretch, send_calm);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Sink: hold ready low for a drawn number of cycles after each transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) take_wait = draw_wait(take_stretch, take_calm);
         else if (take_wait > 0) take_wait--;
         rsp_if.ready <= (take_wait == 0);
      end
   end

   // Monitor: check each result transfer, predict on each input transfer
   always @(posedge clock) begin
      output_sample_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_outputs.size() == 0) begin
            $display("%0t: result with none expected: sample %0d channel %0d index %0d final %0b",
                     $time, rsp_if.out_sample, rsp_if.out_channel, rsp_if.out_index,
                     rsp_if.final_res);
            error_count++;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_if.out_sample !== want.sum) begin
               $display("%0t: out_sample expected %0d actual %0d",
                        $time, want.sum, rsp_if.out_sample);
               error_count++;
            end
            if (rsp_if.out_channel !== want.channel) begin
               $display("%0t: out_channel expected %0d actual %0d",
                        $time, want.channel, rsp_if.out_channel);
               error_count++;
            end
            if (rsp_if.out_index !== want.index) begin
               $display("%0t: out_index expected %0d actual %0d",
                        $time, want.index, rsp_if.out_index);
               error_count++;
            end
            if (rsp_if.final_res !== want.is_final) begin
               $display("%0t: final_res expected %0b actual %0b",
                        $time, want.is_final, rsp_if.final_res);
               error_count++;
            end
         end
      end
      if (!reset && req_if.valid && req_if.ready) begin
         accepted_count++;
         predict_overlap_add(req_if.sample);
      end
   end

   // Watchdog: end the run after too long without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Write all four registers; the block is idle when this is called
   task automatic write_config(input logic [TAPS_REG_W-1:0] t,
                               input logic [STRIDE_REG_W-1:0] s,
                               input logic [CHANNELS_REG_W-1:0] c,
                               input logic [POSITIONS_REG_W-1:0] p);
      taps_reg   = t;
      stride_reg = s;
      chan_reg   = c;
      pos_reg    = p;
      write_register(CSR_TAPS, CSR_DATA_W'(t));
      write_register(CSR_STRIDE, CSR_DATA_W'(s));
      write_register(CSR_CHANNELS, CSR_DATA_W'(c));
      write_register(CSR_POSITIONS, CSR_DATA_W'(p));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Queue a batch, then wait until every transfer and result is done
   task automatic send_samples(input sample_q_type items);
      @(negedge clock);
      foreach (items[i]) pending_samples.push_back(items[i]);
      pushed_count += items.size();
      while (accepted_count != pushed_count || expected_outputs.size() != 0)
         @(posedge clock);
      // let a trailing store write back before anything changes
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] draw_sample(input sample_mode_type mode,
                                                              input int unsigned i);
      case (mode)
         SAMPLE_MAX:       return SAMPLE_HI;
         SAMPLE_MIN:       return SAMPLE_LO;
         SAMPLE_ALTERNATE: return i[0] ? SAMPLE_LO : SAMPLE_HI;
         SAMPLE_SMALL:     return SAMPLE_W'($signed($urandom_range(0, 200)) - 100);
         default:          return SAMPLE_W'($urandom());
      endcase
   endfunction

   initial begin
      logic [TAPS_REG_W-1:0]      t_reg;
      logic [STRIDE_REG_W-1:0]    s_reg;
      logic [CHANNELS_REG_W-1:0]  c_reg;
      logic [POSITIONS_REG_W-1:0] p_reg;
      lim_type         lim;
      sample_mode_type mode;
      int unsigned     n, remaining, tries, random_items;

      req_if.valid  = 1'b0;
      req_if.sample = '0;
      rsp_if.ready  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: the first taps of position zero pass straight through
      batch = '{SAMPLE_HI, SAMPLE_LO, 24'sd0};
      send_samples(batch);

      // two taps, unit stride, three positions; tap counter starts past its limit
      write_config(6'd2, 6'd1, 9'd1, 17'd3);
      batch = '{SAMPLE_HI, SAMPLE_HI, SAMPLE_LO, SAMPLE_LO, -24'sd1, 24'sd1};
      send_samples(batch);

      // all registers zero: clamped to one, every value is a final sample
      write_config(6'd0, 6'd0, 9'd0, 17'd0);
      batch = '{24'sd5, -24'sd5};
      send_samples(batch);

      // all registers at their top codes: clamped to the largest transform
      write_config(6'd63, 6'd63, 9'd511, 17'd131071);
      batch = '{SAMPLE_HI, SAMPLE_LO, 24'sh555555, 24'shAAAAAA};
      send_samples(batch);

      // three taps, stride two, a full two-position transform
      write_config(6'd3, 6'd2, 9'd1, 17'd2);
      batch = '{SAMPLE_HI, 24'sd7, SAMPLE_HI, SAMPLE_LO, SAMPLE_LO, 24'sd3};
      send_samples(batch);

      // random settings, mostly whole transforms, some cut short mid-stream
      random_items = 0;
      tries = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       t_reg = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
            1:       t_reg = 6'($urandom_range(9, 32));
            2:       t_reg = 6'd32;
            default: t_reg = 6'($urandom_range(1, 8));
         endcase
         lim = clamp_limits(t_reg, 6'd1, 9'd1, 17'd1);
         if ($urandom_range(0, 7) == 0) s_reg = 6'($urandom_range(0, 63));
         else s_reg = 6'($urandom_range(1, lim.k));
         case ($urandom_range(0, 9))
            0:       c_reg = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(257, 511));
            1:       c_reg = 9'd256;
            2:       c_reg = 9'($urandom_range(5, 32));
            default: c_reg = 9'($urandom_range(1, 4));
         endcase
         case ($urandom_range(0, 9))
            0:       p_reg = $urandom_range(0, 1) ? 17'd0 : 17'($urandom_range(65536, 131071));
            1:       p_reg = 17'($urandom_range(7, 40));
            default: p_reg = 17'($urandom_range(1, 6));
         endcase
         lim = clamp_limits(t_reg, s_reg, c_reg, p_reg);
         remaining = items_to_end(lim);
         n = (remaining <= 320 && $urandom_range(0, 4) != 0) ? remaining
                                                             : $urandom_range(1, 160);
         if (n > remaining) n = remaining;
         tries++;
         if (!reads_covered(lim, n)) begin
            if (tries < 40) continue;
            // fall back to a single position: no overlap reads at all
            p_reg = '0;
            lim   = clamp_limits(t_reg, s_reg, c_reg, p_reg);
            n     = items_to_end(lim);
            if (n > 160) n = 160;
         end
         tries = 0;
         case ($urandom_range(0, 9))
            0:       mode = SAMPLE_MAX;
            1:       mode = SAMPLE_MIN;
            2:       mode = SAMPLE_ALTERNATE;
            3:       mode = SAMPLE_SMALL;
            default: mode = SAMPLE_RANDOM;
         endcase
         write_config(t_reg, s_reg, c_reg, p_reg);
         batch.delete();
         for (int unsigned i = 0; i < n; i++) batch.push_back(draw_sample(mode, i));
         send_samples(batch);
         random_items += n;
      end

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
